@@ src/erfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// erfsa_pkg
// Shared widths, constants and bus types of the error function pipeline.
// ----------------------------------------------------------------------------
package erfsa_pkg;

	// series term magnitude (Q32), partial sum (Q32 signed), z squared (Q24)
	localparam int unsigned T_W = 37;
	localparam int unsigned S_W = 40;
	localparam int unsigned W_W = 27;
	localparam int unsigned P_W = 40;
	localparam int unsigned A_W = 14;

	// tail divider: numerator, quotient and divisor widths
	localparam int unsigned TN_W = 30;
	localparam int unsigned TQ_W = 16;
	localparam int unsigned TD_W = 16;

	// remainder width of the constant dividers, divisors up to 63
	localparam int unsigned D_W = 6;

	// quotient bits resolved per stage of the tail divider
	localparam int unsigned TAIL_STEPS = 2;

	localparam logic [14:0] ERF2_RESET = 15'd32616;
	localparam logic [14:0] Q15_MAX    = 15'h7fff;
	localparam logic [15:0] TWO_Q12    = 16'd8192;
	localparam logic [16:0] ONE_Q15    = 17'd32768;
	localparam logic [30:0] K_Q30      = 31'd1211587905;

	// front end bus carried alongside the tail division
	typedef struct packed {
		logic           zneg;
		logic           tail;
		logic [A_W-1:0] a;
		logic [W_W-1:0] w;
	} front_bus_t;

	// bus handed from cell to cell
	typedef struct packed {
		logic [T_W-1:0]        t;
		logic signed [S_W-1:0] s;
		logic [W_W-1:0]        w;
		logic                  zneg;
		logic                  tail;
		logic [14:0]           tmag;
	} cell_bus_t;

endpackage

@@ src/erfsa_div.sv @@
// ----------------------------------------------------------------------------
// erfsa_div
// Pipelined restoring divider, a fixed number of quotient bits per stage,
// with a side vector that travels along with each request.
// ----------------------------------------------------------------------------
module erfsa_div import erfsa_pkg::*; #(
	parameter int unsigned NW    = 40,
	parameter int unsigned QW    = 40,
	parameter int unsigned DW    = 6,
	parameter int unsigned STEPS = 8,
	parameter int unsigned SW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	localparam int unsigned NST  = (QW + STEPS - 1) / STEPS;
	localparam int unsigned SKIP = NST * STEPS - QW;

	logic          vld_s  [NST];
	logic [DW-1:0] rem_s  [NST];
	logic [QW-1:0] quo_s  [NST];
	logic [QW-1:0] lo_s   [NST];
	logic [DW-1:0] den_s  [NST];
	logic [SW-1:0] side_s [NST];

	logic [DW-1:0] rem_n [NST];
	logic [QW-1:0] quo_n [NST];
	logic [QW-1:0] lo_n  [NST];
	logic [DW-1:0] hi;

	// upper numerator bits start as the remainder; caller keeps them below den
	assign hi = DW'(num >> QW);

	// resolve STEPS quotient bits in each stage
	always_comb begin
		logic [DW:0]   tt;
		logic [DW-1:0] r;
		logic [DW-1:0] dv;
		logic [QW-1:0] qv;
		logic [QW-1:0] lv;
		for (int k = 0; k < NST; k++) begin
			if (k == 0) begin
				r  = hi;
				qv = '0;
				lv = num[QW-1:0];
				dv = den;
			end else begin
				r  = rem_s[k-1];
				qv = quo_s[k-1];
				lv = lo_s[k-1];
				dv = den_s[k-1];
			end
			for (int i = 0; i < STEPS; i++) begin
				if (k * STEPS + i >= SKIP) begin
					tt = {r, lv[QW-1]};
					lv = lv << 1;
					if (tt >= {1'b0, dv}) begin
						tt = tt - {1'b0, dv};
						qv = {qv[QW-2:0], 1'b1};
					end else begin
						qv = {qv[QW-2:0], 1'b0};
					end
					r = tt[DW-1:0];
				end
			end
			rem_n[k] = r;
			quo_n[k] = qv;
			lo_n[k]  = lv;
		end
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
				lo_s[k]  <= lo_n[k];
			end
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int k = 1; k < NST; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign quo       = quo_s[NST-1];
	assign side_out  = side_s[NST-1];

endmodule

// ----------------------------------------------------------------------------
// erfsa_kdiv
// Pipelined divider by a constant up to 63: one 8-bit quotient digit per
// stage, each digit by reciprocal multiplication of remainder and next
// numerator byte, with a side vector that travels along with each request.
// ----------------------------------------------------------------------------
module erfsa_kdiv import erfsa_pkg::*; #(
	parameter int unsigned NW = 40,
	parameter int unsigned KD = 3,
	parameter int unsigned SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	localparam int unsigned NST = (NW + 7) / 8;
	localparam int unsigned PW  = NST * 8;
	localparam int unsigned XW  = D_W + 8;
	// shift wide enough that the rounded-up reciprocal is exact for XW bits
	localparam int unsigned RSH = XW + D_W;
	localparam logic [XW+RSH:0] RECIP =
		(XW + RSH + 1)'(((64'd1 << RSH) + 64'(KD) - 64'd1) / 64'(KD));
	localparam logic [XW-1:0] KDX = XW'(KD);

	logic           vld_s  [NST];
	logic [D_W-1:0] rem_s  [NST];
	logic [PW-1:0]  num_s  [NST];
	logic [PW-1:0]  quo_s  [NST];
	logic [SW-1:0]  side_s [NST];

	logic [D_W-1:0] rem_n [NST];
	logic [PW-1:0]  num_n [NST];
	logic [PW-1:0]  quo_n [NST];

	// resolve one quotient byte in each stage
	always_comb begin
		logic [D_W-1:0]  r;
		logic [PW-1:0]   nv;
		logic [PW-1:0]   qv;
		logic [XW-1:0]   x;
		logic [XW+RSH:0] pr;
		logic [7:0]      qd;
		for (int k = 0; k < NST; k++) begin
			if (k == 0) begin
				r  = '0;
				nv = PW'(num);
				qv = '0;
			end else begin
				r  = rem_s[k-1];
				nv = num_s[k-1];
				qv = quo_s[k-1];
			end
			x  = {r, nv[PW-1 -: 8]};
			pr = (XW + RSH + 1)'(x) * RECIP;
			qd = pr[RSH +: 8];
			r  = D_W'(x - XW'(qd) * KDX);
			rem_n[k] = r;
			num_n[k] = nv << 8;
			quo_n[k] = {qv[PW-9:0], qd};
		end
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) begin
				rem_s[k] <= rem_n[k];
				num_s[k] <= num_n[k];
				quo_s[k] <= quo_n[k];
			end
			side_s[0] <= side_in;
			for (int k = 1; k < NST; k++) side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = vld_s[NST-1];
	assign quo       = quo_s[NST-1][NW-1:0];
	assign side_out  = side_s[NST-1];

endmodule

@@ src/erfsa_cell.sv @@
// ----------------------------------------------------------------------------
// erfsa_cell
// One series term: t_n = ((t_{n-1} * w) >> 24) / n, then adds or subtracts
// t_n / (2n+1) to the running sum and hands the bus to the next cell.
// ----------------------------------------------------------------------------
module erfsa_cell import erfsa_pkg::*; #(
	parameter int unsigned N = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  cell_bus_t in_bus,
	output logic      out_valid,
	output cell_bus_t out_bus
);

	localparam bit ODD = (N % 2) == 1;

	logic            v_s1;
	logic [45:0]     ph_s1;
	logic [44:0]     pl_s1;
	cell_bus_t       bus_s1;
	logic [63:0]     prod;
	logic            v_s2;
	logic [P_W-1:0]  p_s2;
	cell_bus_t       bus_s2;
	logic            v_d1;
	logic [P_W-1:0]  q1;
	cell_bus_t       bus_d1;
	cell_bus_t       bus_tn;
	logic            v_d2;
	logic [T_W-1:0]  q2;
	cell_bus_t       bus_d2;
	cell_bus_t       bus_acc;
	logic            v_s3;
	cell_bus_t       bus_s3;

	// hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_d2;
		end
	end

	// split the product into two partial products, then join them
	assign prod = {ph_s1, 18'd0} + 64'(pl_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= in_bus.t[36:18] * in_bus.w;
			pl_s1  <= in_bus.t[17:0] * in_bus.w;
			bus_s1 <= in_bus;
			p_s2   <= prod[63:24];
			bus_s2 <= bus_s1;
		end
	end

	// divide by the term index
	erfsa_kdiv #(
		.NW(P_W), .KD(N), .SW($bits(cell_bus_t))
	) u_div_n (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .num(p_s2), .side_in(bus_s2),
		.out_valid(v_d1), .quo(q1), .side_out(bus_d1)
	);

	// replace the term with the new one
	always_comb begin
		bus_tn   = bus_d1;
		bus_tn.t = q1[T_W-1:0];
	end

	// divide by twice the index plus one
	erfsa_kdiv #(
		.NW(T_W), .KD(2 * N + 1), .SW($bits(cell_bus_t))
	) u_div_odd (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_d1), .num(bus_tn.t), .side_in(bus_tn),
		.out_valid(v_d2), .quo(q2), .side_out(bus_d2)
	);

	// accumulate with alternating sign
	always_comb begin
		bus_acc = bus_d2;
		if (ODD) bus_acc.s = bus_d2.s - $signed(S_W'(q2));
		else     bus_acc.s = bus_d2.s + $signed(S_W'(q2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_s3 <= bus_acc;
		end
	end

	assign out_valid = v_s3;
	assign out_bus   = bus_s3;

endmodule

@@ src/erf_series_approximation.sv @@
// ----------------------------------------------------------------------------
// erf_series_approximation
// erf(z) for Q3.12 z into Q1.15: Maclaurin series up to |z| = 2, tail form
// beyond, saturated, odd-symmetric.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while z_stall is low; the row of cells
//   takes a new one each cycle that the pipeline is not frozen.
// Reset: arst_n clears all valid bits and the output buffer, erf_at_two
//   returns to 32616; no clearing pass, requests are taken right after reset.
module erf_series_approximation import erfsa_pkg::*; #(
	parameter int unsigned SERIES_TERMS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [14:0] cfg_wdata,
	input  logic        z_valid,
	output logic        z_stall,
	input  logic signed [15:0] z,
	output logic        erf_valid,
	input  logic        erf_stall,
	output logic signed [15:0] erf_value
);

	logic        en;
	logic [14:0] erf_at_two_q;

	logic        v_s1;
	logic        zneg_s1;
	logic        tail_s1;
	logic [15:0] mag_s1;
	logic [15:0] zu;
	logic [15:0] magc;

	logic [A_W-1:0]  a_c;
	logic [27:0]     sq;
	logic [14:0]     dd;
	logic [15:0]     ome;
	logic [30:0]     tprod;
	logic            v_s2;
	front_bus_t      fbus_s2;
	logic [TN_W-1:0] num_s2;
	logic [TD_W-1:0] den_s2;

	logic            fv;
	logic [TQ_W-1:0] fq;
	front_bus_t      fbus;
	logic [16:0]     tsum;

	logic      chain_v   [SERIES_TERMS];
	cell_bus_t chain_bus [SERIES_TERMS];

	logic [S_W-1:0] sabs;
	logic        v_s3;
	logic [27:0] sm_s3;
	logic        sneg_s3;
	cell_bus_t   bus_s3;
	logic        v_s4;
	logic [58:0] prod_s4;
	logic        sneg_s4;
	cell_bus_t   bus_s4;
	logic [59:0] rsum;
	logic [24:0] rr;
	logic [14:0] smag;
	logic [14:0] rmag;
	logic        rneg;
	logic [15:0] fin_res;
	logic        fin_valid;

	logic [1:0]  cnt_q;
	logic [15:0] head_q;
	logic [15:0] next_q;
	logic        push;
	logic        pop;

	// freeze the whole pipeline only while the output buffer is full
	assign en      = (cnt_q != 2'd2);
	assign z_stall = !en;

	// hold the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) erf_at_two_q <= ERF2_RESET;
		else if (cfg_wen) erf_at_two_q <= cfg_wdata;
	end

	// take magnitude and pick the path
	assign zu   = z;
	assign magc = zu[15] ? 16'(-zu) : zu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= z_valid;
			v_s2 <= v_s1;
			v_s3 <= chain_v[SERIES_TERMS-1];
			v_s4 <= v_s3;
		end
	end

	// square the argument and form the tail numerator
	assign a_c   = tail_s1 ? '0 : mag_s1[A_W-1:0];
	assign sq    = a_c * a_c;
	assign dd    = 15'(mag_s1 - TWO_Q12);
	assign ome   = 16'(ONE_Q15 - 17'(erf_at_two_q));
	assign tprod = dd * ome;

	always_ff @(posedge clk) begin
		if (en) begin
			zneg_s1      <= zu[15];
			tail_s1      <= magc > TWO_Q12;
			mag_s1       <= magc;
			fbus_s2.zneg <= zneg_s1;
			fbus_s2.tail <= tail_s1;
			fbus_s2.a    <= a_c;
			fbus_s2.w    <= sq[W_W-1:0];
			num_s2       <= tail_s1 ? TN_W'(tprod) + TN_W'(mag_s1 >> 1) : '0;
			den_s2       <= tail_s1 ? mag_s1 : 16'd1;
		end
	end

	// divide the tail numerator by the magnitude
	erfsa_div #(
		.NW(TN_W), .QW(TQ_W), .DW(TD_W), .STEPS(TAIL_STEPS), .SW($bits(front_bus_t))
	) u_div_tail (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .num(num_s2), .den(den_s2), .side_in(fbus_s2),
		.out_valid(fv), .quo(fq), .side_out(fbus)
	);

	// seed the row of cells with the first term
	assign tsum = 17'(erf_at_two_q) + 17'(fq);

	always_comb begin
		chain_v[0]        = fv;
		chain_bus[0].t    = T_W'({fbus.a, 20'd0});
		chain_bus[0].s    = $signed(S_W'({fbus.a, 20'd0}));
		chain_bus[0].w    = fbus.w;
		chain_bus[0].zneg = fbus.zneg;
		chain_bus[0].tail = fbus.tail;
		chain_bus[0].tmag = (tsum > 17'(Q15_MAX)) ? Q15_MAX : tsum[14:0];
	end

	for (genvar n = 1; n < SERIES_TERMS; n++) begin : g_cell
		erfsa_cell #(.N(n)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(chain_v[n-1]), .in_bus(chain_bus[n-1]),
			.out_valid(chain_v[n]), .out_bus(chain_bus[n])
		);
	end

	// scale the sum magnitude by 2/sqrt(pi)
	assign sabs = chain_bus[SERIES_TERMS-1].s[S_W-1] ?
		S_W'(-chain_bus[SERIES_TERMS-1].s) : S_W'(chain_bus[SERIES_TERMS-1].s);

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s3   <= sabs[S_W-1:12];
			sneg_s3 <= chain_bus[SERIES_TERMS-1].s[S_W-1];
			bus_s3  <= chain_bus[SERIES_TERMS-1];
			prod_s4 <= sm_s3 * K_Q30;
			sneg_s4 <= sneg_s3;
			bus_s4  <= bus_s3;
		end
	end

	// round, saturate, select the path and apply the sign
	assign rsum      = 60'(prod_s4) + (60'd1 << 34);
	assign rr        = rsum[59:35];
	assign smag      = (rr > 25'(Q15_MAX)) ? Q15_MAX : rr[14:0];
	assign rmag      = bus_s4.tail ? bus_s4.tmag : smag;
	assign rneg      = bus_s4.zneg ^ (!bus_s4.tail & sneg_s4);
	assign fin_res   = rneg ? 16'(-{1'b0, rmag}) : {1'b0, rmag};
	assign fin_valid = v_s4;

	// buffer up to two results; the pipeline freezes only while both are held
	assign push = en && fin_valid;
	assign pop  = erf_valid && !erf_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else cnt_q <= cnt_q + 2'(push) - 2'(pop);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) head_q <= next_q;
			else if (push) head_q <= fin_res;
		end else if (push) begin
			if (cnt_q == 2'd0) head_q <= fin_res;
			else next_q <= fin_res;
		end
	end

	assign erf_valid = (cnt_q != 2'd0);
	assign erf_value = head_q;

	// buffer never overflows
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output buffer count out of range");

	// a full buffer freezes the pipeline output
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |=> $stable(fin_valid) && $stable(fin_res))
		else $error("pipeline moved while output buffer was full");

	// draining the last buffered result empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && pop && !push) |=> !erf_valid)
		else $error("stale result after drain");

	// saturation keeps the most negative code out
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		erf_valid |-> erf_value != 16'sh8000) else $error("result not saturated");

endmodule
